### rtl/trd_pkg.sv
// Shared types and constants for the tunnel record deframer.
package trd_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [3:0] frame_type_type;
   typedef logic [15:0] length_type;
   typedef logic [2:0] header_index_type;

   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_INCOMPLETE   = 3'd1,
      STATUS_BAD_MAGIC    = 3'd2,
      STATUS_UNKNOWN_TYPE = 3'd3,
      STATUS_TRAILING     = 3'd4
   } status_type;

   // Header byte positions.
   localparam header_index_type HDR_LEN_HIGH = 3'd4;
   localparam header_index_type HDR_LEN_LOW  = 3'd5;
   localparam header_index_type HDR_TYPE     = 3'd6;
   localparam header_index_type HDR_RESERVED = 3'd7;

   // Magic bytes followed by the version byte.
   localparam byte_type MAGIC [4] = '{8'h53, 8'h54, 8'h46, 8'h01};

   localparam byte_type TAG_DATA       = 8'h00;
   localparam byte_type TAG_DPD_REQ    = 8'h03;
   localparam byte_type TAG_DPD_RESP   = 8'h04;
   localparam byte_type TAG_DISCONNECT = 8'h05;
   localparam byte_type TAG_KEEPALIVE  = 8'h07;
   localparam byte_type TAG_COMPRESSED = 8'h08;
   localparam byte_type TAG_TERMINATE  = 8'h09;

   function automatic logic tag_known(input byte_type tag);
      return (tag == TAG_DATA) || (tag == TAG_DPD_REQ) || (tag == TAG_DPD_RESP) ||
             (tag == TAG_DISCONNECT) || (tag == TAG_KEEPALIVE) ||
             (tag == TAG_COMPRESSED) || (tag == TAG_TERMINATE);
   endfunction

endpackage

### rtl/trd_channels.sv
// Valid/ready channel interfaces for the deframer's byte input and result output.
interface trd_req_if;
   logic                valid;
   logic                ready;
   trd_pkg::byte_type   data_byte;
   logic                end_of_buffer;

   modport source (output valid, output data_byte, output end_of_buffer, input ready);
   modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface trd_rsp_if;
   logic                     valid;
   logic                     ready;
   logic                     has_payload;
   trd_pkg::byte_type        payload_byte;
   trd_pkg::frame_type_type  frame_type;
   logic                     frame_last;
   trd_pkg::status_type      status;

   modport source (output valid, output has_payload, output payload_byte,
                   output frame_type, output frame_last, output status, input ready);
   modport sink (input valid, input has_payload, input payload_byte,
                 input frame_type, input frame_last, input status, output ready);
endinterface

### rtl/tunnel_record_deframer.sv
// Top level of the tunnel record deframer: header parser, payload pass-through and result register.
// Takes one buffer byte per beat and can accept a beat every clock cycle. Each byte is parsed
// in the cycle it is accepted and any result is registered in a single output register;
// a new byte is accepted whenever that register is empty or being drained in the same cycle, so
// the sustained rate is one byte per cycle. Header bytes, the bytes dropped after an error and
// the trailing bytes after the first give no result; payload bytes, header errors, truncations,
// empty frames and the first trailing byte give exactly one. single_frame_mode should be changed
// only while no byte is in flight.
module tunnel_record_deframer (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic            csr_wr_data,
   trd_req_if.sink         req_if,
   trd_rsp_if.source       rsp_if
);
   import trd_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PAYLOAD,
      PH_DISCARD,
      PH_AFTER
   } phase_type;

   logic              single_frame_ff;
   phase_type         phase_ff, phase_in;
   header_index_type  header_index_ff, header_index_in;
   logic              magic_mismatch_ff, magic_mismatch_in;
   byte_type          type_tag_ff, type_tag_in;
   byte_type          length_high_ff, length_high_in;
   length_type        bytes_remaining_ff, bytes_remaining_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              has_payload_ff, has_payload_in;
   byte_type          payload_byte_ff, payload_byte_in;
   frame_type_type    frame_type_ff, frame_type_in;
   logic              frame_last_ff, frame_last_in;
   status_type        status_ff, status_in;

   logic              accept;
   logic              emit;
   logic              eob;
   byte_type          din;
   length_type        remaining_dec;

   assign req_if.ready  = !rsp_valid_ff || rsp_if.ready;
   assign accept        = req_if.valid && req_if.ready;
   assign eob           = req_if.end_of_buffer;
   assign din           = req_if.data_byte;
   assign remaining_dec = bytes_remaining_ff - 16'd1;

   always_comb begin
      phase_in           = phase_ff;
      header_index_in    = header_index_ff;
      magic_mismatch_in  = magic_mismatch_ff;
      type_tag_in        = type_tag_ff;
      length_high_in     = length_high_ff;
      bytes_remaining_in = bytes_remaining_ff;
      emit               = 1'b0;
      has_payload_in     = 1'b0;
      payload_byte_in    = '0;
      frame_type_in      = '0;
      frame_last_in      = 1'b1;
      status_in          = STATUS_OK;

      unique case (phase_ff)
         PH_HEADER: begin
            if (header_index_ff != HDR_RESERVED) begin
               if (header_index_ff < HDR_LEN_HIGH) begin
                  if (din != MAGIC[header_index_ff[1:0]]) begin
                     magic_mismatch_in = 1'b1;
                  end
               end else if (header_index_ff == HDR_LEN_HIGH) begin
                  length_high_in = din;
               end else if (header_index_ff == HDR_LEN_LOW) begin
                  bytes_remaining_in = {length_high_ff, din};
               end else begin
                  type_tag_in = din;
               end
               if (eob) begin
                  // A short header is reported as incomplete before any other fault.
                  header_index_in   = '0;
                  magic_mismatch_in = 1'b0;
                  emit              = 1'b1;
                  status_in         = STATUS_INCOMPLETE;
               end else begin
                  header_index_in = header_index_ff + 3'd1;
               end
            end else begin
               header_index_in   = '0;
               magic_mismatch_in = 1'b0;
               emit              = 1'b1;
               if (magic_mismatch_ff || !tag_known(type_tag_ff)) begin
                  status_in = magic_mismatch_ff ? STATUS_BAD_MAGIC : STATUS_UNKNOWN_TYPE;
                  phase_in  = eob ? PH_HEADER : PH_DISCARD;
               end else if (bytes_remaining_ff == '0) begin
                  frame_type_in = type_tag_ff[3:0];
                  phase_in      = (eob || !single_frame_ff) ? PH_HEADER : PH_AFTER;
               end else if (eob) begin
                  status_in = STATUS_INCOMPLETE;
               end else begin
                  emit     = 1'b0;
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            emit               = 1'b1;
            bytes_remaining_in = remaining_dec;
            if (remaining_dec == '0) begin
               has_payload_in  = 1'b1;
               payload_byte_in = din;
               frame_type_in   = type_tag_ff[3:0];
               phase_in        = (eob || !single_frame_ff) ? PH_HEADER : PH_AFTER;
            end else if (eob) begin
               // The byte that cuts the payload short is not passed on.
               bytes_remaining_in = '0;
               phase_in           = PH_HEADER;
               status_in          = STATUS_INCOMPLETE;
            end else begin
               has_payload_in  = 1'b1;
               payload_byte_in = din;
               frame_type_in   = type_tag_ff[3:0];
               frame_last_in   = 1'b0;
            end
         end
         PH_AFTER: begin
            emit      = 1'b1;
            status_in = STATUS_TRAILING;
            phase_in  = eob ? PH_HEADER : PH_DISCARD;
         end
         PH_DISCARD: begin
            if (eob) begin
               phase_in = PH_HEADER;
            end
         end
         default: begin
            phase_in = PH_HEADER;
         end
      endcase

      if (accept) begin
         rsp_valid_in = emit;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         single_frame_ff    <= 1'b0;
         phase_ff           <= PH_HEADER;
         header_index_ff    <= '0;
         magic_mismatch_ff  <= 1'b0;
         type_tag_ff        <= '0;
         length_high_ff     <= '0;
         bytes_remaining_ff <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            single_frame_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff           <= phase_in;
            header_index_ff    <= header_index_in;
            magic_mismatch_ff  <= magic_mismatch_in;
            type_tag_ff        <= type_tag_in;
            length_high_ff     <= length_high_in;
            bytes_remaining_ff <= bytes_remaining_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         has_payload_ff  <= has_payload_in;
         payload_byte_ff <= payload_byte_in;
         frame_type_ff   <= frame_type_in;
         frame_last_ff   <= frame_last_in;
         status_ff       <= status_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.has_payload  = has_payload_ff;
   assign rsp_if.payload_byte = payload_byte_ff;
   assign rsp_if.frame_type   = frame_type_ff;
   assign rsp_if.frame_last   = frame_last_ff;
   assign rsp_if.status       = status_ff;

   // A result without a payload byte always closes a frame or reports an error.
   a_empty_result_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !has_payload_ff) |-> frame_last_ff)
      else $error("result without payload is not marked last");

   // Error results carry no frame type.
   a_error_has_no_type: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != STATUS_OK) |-> (frame_type_ff == '0 && !has_payload_ff))
      else $error("error result carries a type or payload");

   // The payload phase is only ever entered with bytes still owed.
   a_payload_count_live: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (bytes_remaining_ff != '0))
      else $error("payload phase with zero bytes remaining");

   // The header position is parked at zero outside the header phase.
   a_header_index_parked: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_HEADER) |-> (header_index_ff == '0 && !magic_mismatch_ff))
      else $error("header position not cleared outside the header");

endmodule
